>>> rtl/tpcw_pkg.sv
// Shared types, constants and register codes for the thruster pulse commander.
package tpcw_pkg;

    localparam int LANES         = 8;
    localparam int NUM_THRUSTERS = 8;

    localparam int ID_W    = 11;
    localparam int LEVEL_W = 8;
    localparam int PULSE_W = 12;
    localparam int COUNT_W = 16;
    localparam int GAIN_W  = 4;
    localparam int DATA_W  = 16;
    localparam int IDX_W   = 3;

    localparam int LEVEL_LIMIT = 100;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [ID_W-1:0]    RST_CMD_ID  = ID_W'(33);
    localparam logic [ID_W-1:0]    RST_HB_ID   = ID_W'(126);
    localparam logic [COUNT_W-1:0] RST_TIMEOUT = COUNT_W'(1000);
    localparam logic [PULSE_W-1:0] RST_NEUTRAL = PULSE_W'(1500);
    localparam logic [PULSE_W-1:0] RST_MIN     = PULSE_W'(1100);
    localparam logic [PULSE_W-1:0] RST_MAX     = PULSE_W'(1900);
    localparam logic [GAIN_W-1:0]  RST_GAIN    = GAIN_W'(4);

    typedef enum logic [IDX_W-1:0] {
        REG_CMD_ID  = 3'd0,
        REG_HB_ID   = 3'd1,
        REG_TIMEOUT = 3'd2,
        REG_NEUTRAL = 3'd3,
        REG_MIN     = 3'd4,
        REG_MAX     = 3'd5,
        REG_GAIN    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [ID_W-1:0]    cmd_id;
        logic [ID_W-1:0]    hb_id;
        logic [COUNT_W-1:0] timeout;
        logic [PULSE_W-1:0] neutral;
        logic [PULSE_W-1:0] pmin;
        logic [PULSE_W-1:0] pmax;
        logic [GAIN_W-1:0]  gain;
    } cfg_t;

    typedef struct packed {
        logic armed;
        logic link;
        logic reply;
    } status_t;

    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef level_t level_arr_t [LANES];

    typedef logic [PULSE_W-1:0] pulse_t;
    typedef pulse_t pulse_arr_t [LANES];

endpackage

>>> rtl/tpcw_lane.sv
// One thruster lane: level clamp, gain scaling, pulse limit, neutral when unarmed.
module tpcw_lane (
    input  tpcw_pkg::level_t level,
    input  logic             armed,
    input  tpcw_pkg::cfg_t   cfg,
    output tpcw_pkg::pulse_t pulse
);
    import tpcw_pkg::*;

    localparam int PROD_W = LEVEL_W + GAIN_W + 1;
    localparam int SUM_W  = PULSE_W + 2;

    level_t                    level_c;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   lo_c;
    logic signed [SUM_W-1:0]   hi_c;
    logic signed [SUM_W-1:0]   min_s;
    logic signed [SUM_W-1:0]   max_s;

    always_comb
    begin
        if (level < -LEVEL_W'(LEVEL_LIMIT))
            level_c = -LEVEL_W'(LEVEL_LIMIT);
        else if (level > LEVEL_W'(LEVEL_LIMIT))
            level_c = LEVEL_W'(LEVEL_LIMIT);
        else
            level_c = level;
    end

    assign prod  = PROD_W'(level_c) * $signed({1'b0, cfg.gain});
    assign sum   = $signed({2'b00, cfg.neutral}) + SUM_W'(prod);
    assign min_s = $signed({2'b00, cfg.pmin});
    assign max_s = $signed({2'b00, cfg.pmax});
    assign lo_c  = (sum < min_s) ? min_s : sum;
    assign hi_c  = (lo_c > max_s) ? max_s : lo_c;

    assign pulse = armed ? hi_c[PULSE_W-1:0] : cfg.neutral;

endmodule

>>> rtl/tpcw_watchdog.sv
// Command state: stored levels, armed and link flags, tick counter with timeout.
module tpcw_watchdog (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 opcode,
    input  logic [tpcw_pkg::ID_W-1:0] frame_id,
    input  tpcw_pkg::level_arr_t levels,
    input  tpcw_pkg::cfg_t       cfg,
    output tpcw_pkg::level_arr_t level_next,
    output tpcw_pkg::status_t    status_next
);
    import tpcw_pkg::*;

    level_t             level_reg [LANES];
    logic               armed_reg;
    logic               link_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               armed_next;
    logic               link_next;
    logic               reply_next;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;

    assign count_inc = (count_reg != '1) ? count_reg + COUNT_W'(1) : count_reg;

    always_comb
    begin
        armed_next = armed_reg;
        link_next  = link_reg;
        reply_next = 1'b0;
        count_next = count_reg;
        for (int i = 0; i < LANES; i++)
            level_next[i] = level_reg[i];
        if (opcode == OP_FRAME)
        begin
            if (frame_id == cfg.cmd_id)
            begin
                for (int i = 0; i < LANES; i++)
                    if (i < NUM_THRUSTERS)
                        level_next[i] = levels[i];
                count_next = '0;
                link_next  = 1'b1;
                armed_next = 1'b1;
            end
            else if (frame_id == cfg.hb_id)
            begin
                reply_next = 1'b1;
            end
        end
        else
        begin
            count_next = count_inc;
            if (count_inc > cfg.timeout)
            begin
                for (int i = 0; i < LANES; i++)
                    level_next[i] = '0;
                link_next = 1'b0;
            end
        end
    end

    assign status_next = '{armed: armed_next, link: link_next, reply: reply_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANES; i++)
                level_reg[i] <= '0;
            armed_reg <= 1'b0;
            link_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < LANES; i++)
                level_reg[i] <= level_next[i];
            armed_reg <= armed_next;
            link_reg  <= link_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/thruster_pwm_command_watchdog.sv
// Top level: config registers, command state, eight pulse lanes and output word register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  in       | in_valid / in_ready   | opcode, frame_id, level_0..level_7
//  out      | out_valid / out_ready | pulse_0..pulse_7, armed_out, link_out,
//           |                       | heartbeat_reply
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  One word per cycle while in_ready is high; its result appears the cycle after intake.
//  State update and lanes are combinational; the merge registers them as the output word.
//  in_ready is low only while a result word is held and out_ready is low.
//  Reset: levels zero, unarmed, link down, registers at their defaults; no clearing pass.
module thruster_pwm_command_watchdog (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [tpcw_pkg::ID_W-1:0]         frame_id,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_0,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_1,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_2,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_3,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_4,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_5,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_6,
    input  logic signed [tpcw_pkg::LEVEL_W-1:0] level_7,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_0,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_1,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_2,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_3,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_4,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_5,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_6,
    output logic [tpcw_pkg::PULSE_W-1:0]      pulse_7,
    output logic                              armed_out,
    output logic                              link_out,
    output logic                              heartbeat_reply,
    input  logic                              cfg_we,
    input  logic [tpcw_pkg::IDX_W-1:0]        cfg_index,
    input  logic [tpcw_pkg::DATA_W-1:0]       cfg_data
);
    import tpcw_pkg::*;

    cfg_t       cfg_reg;
    level_arr_t levels;
    level_arr_t level_next;
    status_t    status_next;
    pulse_arr_t lane_pulse;
    pulse_arr_t pulse_reg;
    status_t    status_reg;
    logic       out_valid_reg;
    logic       accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign levels[0] = level_0;
    assign levels[1] = level_1;
    assign levels[2] = level_2;
    assign levels[3] = level_3;
    assign levels[4] = level_4;
    assign levels[5] = level_5;
    assign levels[6] = level_6;
    assign levels[7] = level_7;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd_id  <= RST_CMD_ID;
            cfg_reg.hb_id   <= RST_HB_ID;
            cfg_reg.timeout <= RST_TIMEOUT;
            cfg_reg.neutral <= RST_NEUTRAL;
            cfg_reg.pmin    <= RST_MIN;
            cfg_reg.pmax    <= RST_MAX;
            cfg_reg.gain    <= RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CMD_ID:  cfg_reg.cmd_id  <= cfg_data[ID_W-1:0];
                REG_HB_ID:   cfg_reg.hb_id   <= cfg_data[ID_W-1:0];
                REG_TIMEOUT: cfg_reg.timeout <= cfg_data[COUNT_W-1:0];
                REG_NEUTRAL: cfg_reg.neutral <= cfg_data[PULSE_W-1:0];
                REG_MIN:     cfg_reg.pmin    <= cfg_data[PULSE_W-1:0];
                REG_MAX:     cfg_reg.pmax    <= cfg_data[PULSE_W-1:0];
                REG_GAIN:    cfg_reg.gain    <= cfg_data[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    tpcw_watchdog u_watchdog (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .frame_id    (frame_id),
        .levels      (levels),
        .cfg         (cfg_reg),
        .level_next  (level_next),
        .status_next (status_next)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        if (g < NUM_THRUSTERS)
        begin : g_on
            tpcw_lane u_lane (
                .level (level_next[g]),
                .armed (status_next.armed),
                .cfg   (cfg_reg),
                .pulse (lane_pulse[g])
            );
        end
        else
        begin : g_off
            assign lane_pulse[g] = '0;
        end
    end

    // merge: lanes and flags into the output word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LANES; i++)
                pulse_reg[i] <= lane_pulse[i];
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign pulse_0         = pulse_reg[0];
    assign pulse_1         = pulse_reg[1];
    assign pulse_2         = pulse_reg[2];
    assign pulse_3         = pulse_reg[3];
    assign pulse_4         = pulse_reg[4];
    assign pulse_5         = pulse_reg[5];
    assign pulse_6         = pulse_reg[6];
    assign pulse_7         = pulse_reg[7];
    assign armed_out       = status_reg.armed;
    assign link_out        = status_reg.link;
    assign heartbeat_reply = status_reg.reply;

`ifndef SYNTH
    a_link_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!link_out || armed_out))
        else $error("link up while unarmed");

    a_reply_source: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (heartbeat_reply == ($past(opcode) == OP_FRAME
            && $past(frame_id) == cfg_reg.hb_id && $past(frame_id) != cfg_reg.cmd_id)))
        else $error("heartbeat reply does not match word taken");

    a_unarmed_neutral: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !armed_out) |-> (pulse_0 == cfg_reg.neutral))
        else $error("unarmed pulse not neutral");

    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && armed_out && accept) |=> armed_out)
        else $error("armed flag dropped");
`endif

endmodule

>>> tb/sv/pulse_word_checker.sv
// Checker: predicts each pulse word from the accepted words and compares it with the block.
module pulse_word_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           opcode,
    input  logic [tpcw_pkg::ID_W-1:0]      frame_id,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_0,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_1,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_2,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_3,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_4,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_5,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_6,
    input  logic [tpcw_pkg::LEVEL_W-1:0]   level_7,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_0,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_1,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_2,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_3,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_4,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_5,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_6,
    input  logic [tpcw_pkg::PULSE_W-1:0]   pulse_7,
    input  logic                           armed_out,
    input  logic                           link_out,
    input  logic                           heartbeat_reply,
    input  logic                           cfg_we,
    input  logic [tpcw_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tpcw_pkg::DATA_W-1:0]    cfg_data,
    output int                             fail_count,
    output int                             words_pending,
    output int                             words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import tpcw_pkg::*;

    typedef struct packed {
        logic [LANES-1:0][PULSE_W-1:0] pulse;
        logic                          armed;
        logic                          link;
        logic                          reply;
    } pulse_word_t;

    cfg_t                          regs;
    level_t                        held_level [LANES];
    logic                          armed;
    logic                          link;
    logic [COUNT_W-1:0]            quiet_ms;
    pulse_word_t                   awaited_words [$];
    int                            n_fail;
    int                            n_checked;

    logic [LANES-1:0][LEVEL_W-1:0] level_in;
    logic [LANES-1:0][PULSE_W-1:0] pulse_seen;

    assign level_in   = {level_7, level_6, level_5, level_4, level_3, level_2, level_1, level_0};
    assign pulse_seen = {pulse_7, pulse_6, pulse_5, pulse_4, pulse_3, pulse_2, pulse_1, pulse_0};

    function automatic pulse_t lane_pulse(input level_t lv);
        int l;
        int p;
        if (!armed)
            return regs.neutral;
        l = lv;
        if (l < -LEVEL_LIMIT)
            l = -LEVEL_LIMIT;
        if (l > LEVEL_LIMIT)
            l = LEVEL_LIMIT;
        p = int'(regs.neutral) + l * int'(regs.gain);
        // max applied last, so it wins when min is above max
        if (p < int'(regs.pmin))
            p = int'(regs.pmin);
        if (p > int'(regs.pmax))
            p = int'(regs.pmax);
        return pulse_t'(p);
    endfunction

    function automatic pulse_word_t next_pulse_word(input logic op, input logic [ID_W-1:0] id,
                                                    input logic [LANES-1:0][LEVEL_W-1:0] lv);
        pulse_word_t w;
        int i;
        w.reply = 1'b0;
        if (op == OP_FRAME) begin
            if (id == regs.cmd_id) begin
                for (i = 0; i < NUM_THRUSTERS; i++)
                    held_level[i] = level_t'(lv[i]);
                quiet_ms = '0;
                link     = 1'b1;
                armed    = 1'b1;
            end
            else if (id == regs.hb_id)
                w.reply = 1'b1;
        end
        else begin
            if (quiet_ms != '1)
                quiet_ms++;
            if (quiet_ms > regs.timeout) begin
                for (i = 0; i < LANES; i++)
                    held_level[i] = '0;
                link = 1'b0;
            end
        end
        for (i = 0; i < LANES; i++)
            w.pulse[i] = (i < NUM_THRUSTERS) ? lane_pulse(held_level[i]) : '0;
        w.armed = armed;
        w.link  = link;
        return w;
    endfunction

    function automatic void flag(input string msg);
        n_fail++;
        $error("%s", msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pulse_word_t want;
        int i;
        if (!rst_n) begin
            regs = '{cmd_id: RST_CMD_ID, hb_id: RST_HB_ID, timeout: RST_TIMEOUT,
                     neutral: RST_NEUTRAL, pmin: RST_MIN, pmax: RST_MAX, gain: RST_GAIN};
            for (i = 0; i < LANES; i++)
                held_level[i] = '0;
            armed     = 1'b0;
            link      = 1'b0;
            quiet_ms  = '0;
            awaited_words.delete();
            n_fail    = 0;
            n_checked = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CMD_ID:  regs.cmd_id  = cfg_data[ID_W-1:0];
                    REG_HB_ID:   regs.hb_id   = cfg_data[ID_W-1:0];
                    REG_TIMEOUT: regs.timeout = cfg_data[COUNT_W-1:0];
                    REG_NEUTRAL: regs.neutral = cfg_data[PULSE_W-1:0];
                    REG_MIN:     regs.pmin    = cfg_data[PULSE_W-1:0];
                    REG_MAX:     regs.pmax    = cfg_data[PULSE_W-1:0];
                    REG_GAIN:    regs.gain    = cfg_data[GAIN_W-1:0];
                    default:     ;
                endcase
            end
            if (out_valid && out_ready) begin
                n_checked++;
                if (awaited_words.size() == 0)
                    flag("result word arrived with none awaited");
                else begin
                    want = awaited_words.pop_front();
                    for (i = 0; i < LANES; i++)
                        if (pulse_seen[i] !== want.pulse[i])
                            flag($sformatf("pulse_%0d: expected %0d, got %0d",
                                           i, want.pulse[i], pulse_seen[i]));
                    if (armed_out !== want.armed)
                        flag($sformatf("armed_out: expected %0b, got %0b",
                                       want.armed, armed_out));
                    if (link_out !== want.link)
                        flag($sformatf("link_out: expected %0b, got %0b",
                                       want.link, link_out));
                    if (heartbeat_reply !== want.reply)
                        flag($sformatf("heartbeat_reply: expected %0b, got %0b",
                                       want.reply, heartbeat_reply));
                end
            end
            if (in_valid && in_ready)
                awaited_words.push_back(next_pulse_word(opcode, frame_id, level_in));
        end
        fail_count    <= n_fail;
        words_pending <= awaited_words.size();
        words_checked <= n_checked;
    end

endmodule

>>> tb/sv/tb_thruster_pwm_command_watchdog.sv
// Testbench top: drives frames, ticks and register writes into the thruster pulse commander.
module tb_thruster_pwm_command_watchdog;
    timeunit 1ns;
    timeprecision 1ps;

    import tpcw_pkg::*;

    typedef logic [LANES-1:0][LEVEL_W-1:0] level_vec_t;

    localparam logic [IDX_W-1:0] REG_SPARE     = 3'd7;
    localparam int               SILENCE_TICKS = 20;
    localparam int               PHASES        = 6;
    localparam int               PHASE_WORDS   = 65;
    localparam level_t           RIM_LEVELS [6] = '{-128, -101, -100, 100, 101, 127};

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               opcode;
    logic [ID_W-1:0]    frame_id;
    logic [LEVEL_W-1:0] lvl_drv [LANES];
    logic               out_valid;
    logic               out_ready;
    logic [PULSE_W-1:0] pulse [LANES];
    logic               armed_out;
    logic               link_out;
    logic               heartbeat_reply;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [DATA_W-1:0]  cfg_data;

    int                 fail_count;
    int                 words_pending;
    int                 words_checked;

    logic [ID_W-1:0]    cur_cmd_id;
    logic [ID_W-1:0]    cur_hb_id;
    bit                 gapless;
    int                 burst_left;
    int                 n_words;
    int                 n_cmd;
    int                 n_hb;
    int                 n_tick;
    int                 n_settings;

    thruster_pwm_command_watchdog dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .frame_id        (frame_id),
        .level_0         (lvl_drv[0]),
        .level_1         (lvl_drv[1]),
        .level_2         (lvl_drv[2]),
        .level_3         (lvl_drv[3]),
        .level_4         (lvl_drv[4]),
        .level_5         (lvl_drv[5]),
        .level_6         (lvl_drv[6]),
        .level_7         (lvl_drv[7]),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pulse_0         (pulse[0]),
        .pulse_1         (pulse[1]),
        .pulse_2         (pulse[2]),
        .pulse_3         (pulse[3]),
        .pulse_4         (pulse[4]),
        .pulse_5         (pulse[5]),
        .pulse_6         (pulse[6]),
        .pulse_7         (pulse[7]),
        .armed_out       (armed_out),
        .link_out        (link_out),
        .heartbeat_reply (heartbeat_reply),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    pulse_word_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .frame_id        (frame_id),
        .level_0         (lvl_drv[0]),
        .level_1         (lvl_drv[1]),
        .level_2         (lvl_drv[2]),
        .level_3         (lvl_drv[3]),
        .level_4         (lvl_drv[4]),
        .level_5         (lvl_drv[5]),
        .level_6         (lvl_drv[6]),
        .level_7         (lvl_drv[7]),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pulse_0         (pulse[0]),
        .pulse_1         (pulse[1]),
        .pulse_2         (pulse[2]),
        .pulse_3         (pulse[3]),
        .pulse_4         (pulse[4]),
        .pulse_5         (pulse[5]),
        .pulse_6         (pulse[6]),
        .pulse_7         (pulse[7]),
        .armed_out       (armed_out),
        .link_out        (link_out),
        .heartbeat_reply (heartbeat_reply),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .words_pending   (words_pending),
        .words_checked   (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: stall mode redrawn at random whenever its random run length runs out
    initial
    begin
        int stall_mode;
        int stall_left;
        out_ready <= 1'b0;
        stall_mode = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 2) != 0);
                2:       out_ready <= (stall_left % 4 != 0);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    function automatic level_vec_t rand_levels();
        level_vec_t v;
        int i;
        for (i = 0; i < LANES; i++)
            case ($urandom_range(0, 3))
                0:       v[i] = LEVEL_W'($urandom);
                1, 2:    v[i] = LEVEL_W'(int'($urandom_range(0, 200)) - 100);
                default: v[i] = RIM_LEVELS[$urandom_range(0, 5)];
            endcase
        return v;
    endfunction

    task automatic send_word(input logic op, input logic [ID_W-1:0] id, input level_vec_t lv);
        int i;
        int gap;
        in_valid <= 1'b1;
        opcode   <= op;
        frame_id <= id;
        for (i = 0; i < LANES; i++)
            lvl_drv[i] <= lv[i];
        do
            @(posedge clk);
        while (!in_ready);
        n_words++;
        if (op == OP_TICK)
            n_tick++;
        else if (id == cur_cmd_id)
            n_cmd++;
        else if (id == cur_hb_id)
            n_hb++;
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 15);
            if (!gapless) begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic random_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_word(OP_TICK, ID_W'($urandom), rand_levels());
        else if (pick < 75)
            send_word(OP_FRAME, cur_cmd_id, rand_levels());
        else if (pick < 87)
            send_word(OP_FRAME, cur_hb_id, rand_levels());
        else
            send_word(OP_FRAME, ID_W'($urandom), rand_levels());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // unused upper data bits carry noise to exercise the register masking
    task automatic put_reg(input logic [IDX_W-1:0] idx, input int unsigned value,
                           input int width);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] data;
        mask = DATA_W'((32'd1 << width) - 1);
        data = DATA_W'($urandom);
        data = (data & ~mask) | (DATA_W'(value) & mask);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input int unsigned cmd, input int unsigned hb,
                                 input int unsigned tmo, input int unsigned neu,
                                 input int unsigned lo, input int unsigned hi,
                                 input int unsigned gain);
        put_reg(REG_CMD_ID, cmd, ID_W);
        put_reg(REG_HB_ID, hb, ID_W);
        put_reg(REG_TIMEOUT, tmo, COUNT_W);
        put_reg(REG_NEUTRAL, neu, PULSE_W);
        put_reg(REG_MIN, lo, PULSE_W);
        put_reg(REG_MAX, hi, PULSE_W);
        put_reg(REG_GAIN, gain, GAIN_W);
        put_reg(REG_SPARE, $urandom, DATA_W);
        cur_cmd_id = ID_W'(cmd);
        cur_hb_id  = ID_W'(hb);
        n_settings++;
    endtask

    initial
    begin
        int ph;
        int k;
        int unsigned cmd;
        int unsigned hb;
        int unsigned tmo;
        int unsigned neu;
        int unsigned lo;
        int unsigned hi;
        int unsigned gain;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_FRAME;
        frame_id  <= '0;
        for (k = 0; k < LANES; k++)
            lvl_drv[k] <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_CMD_ID;
        cfg_data  <= '0;
        cur_cmd_id = RST_CMD_ID;
        cur_hb_id  = RST_HB_ID;
        gapless    = 1'b0;
        burst_left = 0;
        n_words    = 0;
        n_cmd      = 0;
        n_hb       = 0;
        n_tick     = 0;
        n_settings = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings; lane 7 first in the level patterns
        send_word(OP_TICK, '1, rand_levels());
        send_word(OP_FRAME, RST_HB_ID, rand_levels());
        send_word(OP_FRAME, 11'd2047, '1);
        send_word(OP_FRAME, 11'd0, rand_levels());
        send_word(OP_FRAME, RST_CMD_ID, level_vec_t'{-1, 0, 100, -100, 101, -101, 127, -128});
        send_word(OP_FRAME, RST_HB_ID, rand_levels());
        send_word(OP_FRAME, RST_CMD_ID, {4{8'h55, 8'hAA}});
        send_word(OP_TICK, '0, rand_levels());
        settle();

        // equal identifiers, zero timeout, min above max, neutral below both
        load_settings(5, 5, 0, 100, 300, 200, 15);
        send_word(OP_FRAME, 11'd5, level_vec_t'{127, -128, 100, -100, 50, -50, 1, 0});
        send_word(OP_TICK, 11'd5, rand_levels());
        send_word(OP_FRAME, 11'd5, rand_levels());
        send_word(OP_FRAME, 11'd6, rand_levels());
        send_word(OP_TICK, '0, rand_levels());
        settle();

        // neutral near the top, full gain, identifiers at the extremes
        load_settings(2047, 0, 2, 4000, 0, 4095, 15);
        send_word(OP_FRAME, 11'd0, rand_levels());
        send_word(OP_FRAME, 11'd2047, {LANES{8'h7F}});
        send_word(OP_FRAME, 11'd2047, {LANES{8'h80}});
        repeat (3) send_word(OP_TICK, '0, rand_levels());
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: load_settings(0, 0, 0, 0, 0, 0, 0);
                1: load_settings(2047, 2047, 65535, 4095, 4095, 4095, 15);
                default: begin
                    cmd  = $urandom_range(0, 2047);
                    hb   = ($urandom_range(0, 5) == 0) ? cmd : $urandom_range(0, 2047);
                    tmo  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 20);
                    neu  = $urandom_range(900, 2100);
                    lo   = $urandom_range(700, 1500);
                    hi   = $urandom_range(1500, 2300);
                    gain = $urandom_range(0, 15);
                    if ($urandom_range(0, 3) == 0) begin
                        neu = $urandom_range(0, 4095);
                        lo  = $urandom_range(0, 4095);
                        hi  = $urandom_range(0, 4095);
                    end
                    load_settings(cmd, hb, tmo, neu, lo, hi, gain);
                end
            endcase
            gapless = (ph == 3);
            for (k = 0; k < PHASE_WORDS; k++)
                random_word();
            settle();
        end

        // quiet spell under the full timeout, then a lower timeout trips on the next tick
        load_settings(RST_CMD_ID, RST_HB_ID, 65535, RST_NEUTRAL, RST_MIN, RST_MAX, RST_GAIN);
        gapless = 1'b1;
        send_word(OP_FRAME, RST_CMD_ID, rand_levels());
        repeat (SILENCE_TICKS) send_word(OP_TICK, '0, '0);
        settle();
        put_reg(REG_TIMEOUT, 10, COUNT_W);
        gapless = 1'b0;
        send_word(OP_TICK, '0, rand_levels());
        send_word(OP_FRAME, RST_HB_ID, rand_levels());
        settle();

        $display("Run: %0d words in (%0d command frames, %0d heartbeat requests, %0d ticks),",
                 n_words, n_cmd, n_hb, n_tick);
        $display("     %0d register settings, %0d result words checked; %s %0d-tick silence",
                 n_settings, words_checked,
                 "equal identifiers, min above max, stray neutral, zero and full timeouts,",
                 SILENCE_TICKS);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/tpcw_pkg.sv
rtl/tpcw_lane.sv
rtl/tpcw_watchdog.sv
rtl/thruster_pwm_command_watchdog.sv
tb/sv/pulse_word_checker.sv
tb/sv/tb_thruster_pwm_command_watchdog.sv
